### hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold on every clock out of reset
`define CHK_ALWAYS(lbl, ck, rn, ex, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ex)) else $error(msg);

// same-cycle implication
`define CHK_IMPLIES(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/dawt_pkg.sv
`default_nettype none
package dawt_pkg;

	localparam int DEVICES = 16;
	localparam int DEV_W   = $clog2(DEVICES);
	localparam int CNT_W   = $clog2(DEVICES + 1);
	localparam int TIME_W  = 32;
	localparam int TO_W    = 30;
	localparam int CODE_W  = 8;
	localparam int QDEPTH  = 2;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int QFILL_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		REQ_HEARTBEAT = 2'd0,
		REQ_ALARM     = 2'd1,
		REQ_ERROR     = 2'd2,
		REQ_TICK      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_ALARM           = 2'd0,
		KIND_ERROR           = 2'd1,
		KIND_NO_CONTACT      = 2'd2,
		KIND_NO_CONTACT_FIRE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_COUNTING = 2'd1,
		PH_ALERTED  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_ALARM_TIMEOUT   = 2'd0,
		REG_CONTACT_TIMEOUT = 2'd1,
		REG_DEVICE_COUNT    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		req_t              op;
		logic [DEV_W-1:0]  dev;
		logic [CODE_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [TO_W-1:0]  alarm_to;
		logic [TO_W-1:0]  contact_to;
		logic [CNT_W-1:0] eff_count;
	} cfg_t;

	typedef struct packed {
		logic              last;
		logic [CODE_W-1:0] code;
		kind_t             kind;
		logic [DEV_W-1:0]  dev;
	} alert_t;

endpackage
`default_nettype wire

### hdl/dawt_front.sv
`default_nettype none
module dawt_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [dawt_pkg::CNT_W-1:0]   eff_count,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,
	input  wire logic [1:0]                    s_tuser,
	output logic                               cmd_valid,
	input  wire logic                          cmd_ready,
	output dawt_pkg::cmd_t                     cmd
);

	dawt_pkg::cmd_t                      q_q [dawt_pkg::QDEPTH];
	logic [dawt_pkg::QAW-1:0]            wr_ptr_q;
	logic [dawt_pkg::QAW-1:0]            rd_ptr_q;
	logic [dawt_pkg::QFILL_W-1:0]        fill_q;
	dawt_pkg::cmd_t                      entry;
	logic                                accept;
	logic                                keep;
	logic                                pop;

	always_comb begin
		entry.op   = dawt_pkg::req_t'(s_tuser);
		entry.dev  = s_tdata[dawt_pkg::DEV_W-1:0];
		entry.code = s_tdata[4 +: dawt_pkg::CODE_W];
		s_tready   = fill_q != dawt_pkg::QFILL_W'(dawt_pkg::QDEPTH);
		accept     = s_tvalid && s_tready;
		// requests from devices outside the tracked range are dropped here
		keep       = accept && (entry.op == dawt_pkg::REQ_TICK ||
		             dawt_pkg::CNT_W'(entry.dev) < eff_count);
		cmd_valid  = fill_q != '0;
		cmd        = q_q[rd_ptr_q];
		pop        = cmd_valid && cmd_ready;
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			q_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (keep) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + dawt_pkg::QFILL_W'(keep) - dawt_pkg::QFILL_W'(pop);
		end
	end

endmodule
`default_nettype wire

### hdl/dawt_back.sv
`default_nettype none
module dawt_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dawt_pkg::cfg_t cfg,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire dawt_pkg::cmd_t cmd,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [15:0]         m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	localparam int TW = dawt_pkg::TIME_W;

	state_t                              state_q;
	logic [dawt_pkg::CNT_W-1:0]          idx_q;
	logic [TW-1:0]                       time_q;
	logic [TW-1:0]                       last_contact_q [dawt_pkg::DEVICES];
	logic [TW-1:0]                       alarm_start_q  [dawt_pkg::DEVICES];
	dawt_pkg::phase_t                    phase_q        [dawt_pkg::DEVICES];
	logic [dawt_pkg::DEVICES-1:0]        silenced_q;
	logic                                out_valid_q;
	dawt_pkg::alert_t                    out_q;
	logic                                pend_valid_q;
	dawt_pkg::alert_t                    pend_q;

	logic                                scan;
	logic                                at_end;
	logic                                can_push;
	logic                                pop;
	logic                                dev_step;
	logic [dawt_pkg::DEV_W-1:0]          addr;
	logic [TW-1:0]                       lc;
	logic [TW-1:0]                       as_rd;
	dawt_pkg::phase_t                    ph;
	logic                                sil;
	logic [TW-1:0]                       dc;
	logic [TW-1:0]                       da;
	logic                                contact_exp;
	logic                                alarm_first;
	logic                                alarm_rep;
	logic                                wr_en;
	logic [TW-1:0]                       lc_d;
	logic [TW-1:0]                       as_d;
	dawt_pkg::phase_t                    ph_d;
	logic                                sil_d;
	logic                                new_alert;
	dawt_pkg::alert_t                    new_a;
	logic                                push;
	dawt_pkg::alert_t                    push_a;
	logic                                pend_load;
	logic                                pend_clear;
	logic                                scan_done;

	always_comb begin
		scan     = state_q == ST_SCAN;
		at_end   = idx_q == cfg.eff_count;
		can_push = !out_valid_q || m_tready;
		cmd_ready = !scan && can_push;
		pop      = cmd_valid && cmd_ready;
		dev_step = scan && !at_end && can_push;
		addr     = scan ? idx_q[dawt_pkg::DEV_W-1:0] : cmd.dev;

		lc    = last_contact_q[addr];
		as_rd = alarm_start_q[addr];
		ph    = phase_q[addr];
		sil   = silenced_q[addr];

		// differences are taken as signed; a negative one never times out
		dc = time_q - lc;
		da = time_q - as_rd;
		contact_exp = !sil && !dc[TW-1] && (dc[TW-2:0] > (TW-1)'(cfg.contact_to));
		alarm_first = ph == dawt_pkg::PH_COUNTING && !da[TW-1] &&
		              (da[TW-2:0] > (TW-1)'(cfg.alarm_to));
		alarm_rep   = ph == dawt_pkg::PH_COUNTING && !da[TW-1] &&
		              (da[TW-2:0] > (TW-1)'({cfg.alarm_to, 1'b0}));

		wr_en = 1'b0;
		lc_d  = lc;
		as_d  = as_rd;
		ph_d  = ph;
		sil_d = sil;
		new_alert = 1'b0;
		new_a.last = 1'b0;
		new_a.code = '0;
		new_a.kind = dawt_pkg::KIND_ALARM;
		new_a.dev  = addr;

		if (pop) begin
			case (cmd.op)
				dawt_pkg::REQ_HEARTBEAT: begin
					wr_en = 1'b1;
					lc_d  = time_q;
					sil_d = 1'b0;
					ph_d  = dawt_pkg::PH_IDLE;
				end
				dawt_pkg::REQ_ALARM: begin
					wr_en = 1'b1;
					sil_d = 1'b0;
					// last contact set to the current time minus the alarm timeout plus the contact timeout
					lc_d  = time_q - TW'(cfg.alarm_to) + TW'(cfg.contact_to);
					if (ph == dawt_pkg::PH_IDLE) begin
						ph_d = dawt_pkg::PH_COUNTING;
						as_d = time_q;
					end else if (alarm_first) begin
						ph_d = dawt_pkg::PH_ALERTED;
						new_alert = 1'b1;
					end
				end
				dawt_pkg::REQ_ERROR: begin
					new_alert  = 1'b1;
					new_a.kind = dawt_pkg::KIND_ERROR;
					new_a.code = cmd.code;
				end
				default: begin
				end
			endcase
		end else if (dev_step) begin
			wr_en = 1'b1;
			if (contact_exp) begin
				new_alert  = 1'b1;
				new_a.kind = (ph != dawt_pkg::PH_IDLE) ? dawt_pkg::KIND_NO_CONTACT_FIRE
				                                       : dawt_pkg::KIND_NO_CONTACT;
				sil_d = 1'b1;
				ph_d  = dawt_pkg::PH_IDLE;
			end else if (alarm_rep) begin
				new_alert = 1'b1;
				ph_d      = dawt_pkg::PH_ALERTED;
			end
		end

		// a scan alert waits in pend_q until the next one shows whether it is the last
		push       = 1'b0;
		push_a     = pend_q;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		scan_done  = 1'b0;
		if (pop && new_alert) begin
			push        = 1'b1;
			push_a      = new_a;
			push_a.last = 1'b1;
		end else if (dev_step && new_alert) begin
			pend_load = 1'b1;
			if (pend_valid_q) begin
				push        = 1'b1;
				push_a.last = 1'b0;
			end
		end else if (scan && at_end) begin
			if (!pend_valid_q) begin
				scan_done = 1'b1;
			end else if (can_push) begin
				push        = 1'b1;
				push_a.last = 1'b1;
				pend_clear  = 1'b1;
				scan_done   = 1'b1;
			end
		end

		m_tvalid = out_valid_q;
		m_tdata  = {4'b0, out_q.code, out_q.dev};
		m_tuser  = out_q.kind;
		m_tlast  = out_q.last;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_a;
		end
		if (pend_load) begin
			pend_q <= new_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			time_q       <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			silenced_q   <= '0;
			for (int i = 0; i < dawt_pkg::DEVICES; i++) begin
				last_contact_q[i] <= '0;
				alarm_start_q[i]  <= '0;
				phase_q[i]        <= dawt_pkg::PH_IDLE;
			end
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end
			if (wr_en) begin
				last_contact_q[addr] <= lc_d;
				alarm_start_q[addr]  <= as_d;
				phase_q[addr]        <= ph_d;
				silenced_q[addr]     <= sil_d;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && cmd.op == dawt_pkg::REQ_TICK) begin
						time_q  <= time_q + 1'b1;
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (dev_step) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/device_alarm_watchdog_table_core.sv
// channel   | dir | handshake          | payload
// s_*       | in  | s_tvalid/s_tready  | tdata: device_index, error_code; tuser: req_type
// m_*       | out | m_tvalid/m_tready  | tdata: alert_device, alert_code; tuser: alert_kind;
//           |     |                    | tlast: last_alert
// cfg_*     | in  | cfg_we             | cfg_index selects register, cfg_wdata value
//
// heartbeat, alarm and error requests are handled directly by the back end, without a scan
// a tick starts a scan of the tracked devices: one table entry is checked per cycle while the output is not stalled
// two-entry request queue between front and back; the front accepts while it has room
// a full output register stalls the scan, which resumes without losing state
// arst_n clears time, every table entry and all handshake state at once
`default_nettype none
module device_alarm_watchdog_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [3:0] device_index, [11:4] error_code
	input  wire logic [1:0]  s_tuser,   // [1:0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [3:0] alert_device, [11:4] alert_code
	output logic [1:0]       m_tuser,   // [1:0] alert_kind
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [29:0] cfg_wdata
);

	logic [dawt_pkg::TO_W-1:0] alarm_to_q;
	logic [dawt_pkg::TO_W-1:0] contact_to_q;
	logic [4:0]                device_count_q;
	dawt_pkg::cfg_t            cfg;
	logic                      cmd_valid;
	logic                      cmd_ready;
	dawt_pkg::cmd_t            cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_to_q     <= dawt_pkg::TO_W'(60);
			contact_to_q   <= dawt_pkg::TO_W'(180);
			device_count_q <= 5'd16;
		end else if (cfg_we) begin
			case (dawt_pkg::reg_idx_t'(cfg_index))
				dawt_pkg::REG_ALARM_TIMEOUT:   alarm_to_q     <= cfg_wdata;
				dawt_pkg::REG_CONTACT_TIMEOUT: contact_to_q   <= cfg_wdata;
				dawt_pkg::REG_DEVICE_COUNT:    device_count_q <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.alarm_to   = alarm_to_q;
		cfg.contact_to = contact_to_q;
		cfg.eff_count  = (device_count_q > 5'(dawt_pkg::DEVICES))
		               ? dawt_pkg::CNT_W'(dawt_pkg::DEVICES)
		               : dawt_pkg::CNT_W'(device_count_q);
	end

	dawt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_count (cfg.eff_count),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	dawt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

### hdl/dawt_checker.sv
`default_nettype none
`include "assert_macros.svh"
module dawt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	logic        err_kind;
	logic        code_zero;
	logic        pad_zero;
	logic        stall;
	logic [18:0] out_word;

	assign err_kind  = m_tuser == dawt_pkg::KIND_ERROR;
	assign code_zero = m_tdata[11:4] == 8'd0;
	assign pad_zero  = m_tdata[15:12] == 4'd0;
	assign stall     = m_tvalid && !m_tready;
	assign out_word  = {m_tlast, m_tuser, m_tdata};

	// only error alerts carry a code
	`CHK_IMPLIES(a_code_only_err, clk, arst_n, m_tvalid && !err_kind, code_zero, "stray alert code")

	// an error request yields exactly one alert, so it always closes its group
	`CHK_IMPLIES(a_err_is_last, clk, arst_n, m_tvalid && err_kind, m_tlast, "error alert not last")

	`CHK_IMPLIES(a_pad_zero, clk, arst_n, m_tvalid, pad_zero, "result padding not zero")

	`CHK_NEXT(a_out_hold, clk, arst_n, stall, m_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind device_alarm_watchdog_table_core dawt_checker u_dawt_checker (.*);
`default_nettype wire
